// File: rtl/core/bsa_pkg.sv
`timescale 1ns / 1ps
package bsa_pkg;
  localparam int POOL_PAGES_DEF   = 64;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int SIZE_CLASSES_DEF = 9;
  localparam int MIN_OBJ_BYTES    = 16;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE   = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY   = 2'd2;
  localparam logic [1:0] ST_BAD_ADDRESS = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [12:0] request_length;
    logic [17:0] object_address;
    logic [12:0] size_hint;
  } req_t;

  typedef struct packed {
    logic [17:0] result_address;
    logic [1:0]  status;
    logic        page_released;
  } rsp_t;
endpackage

// File: rtl/core/bsa_stream_if.sv
`timescale 1ns / 1ps
interface bsa_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/bucket_slab_allocator_unit.sv
`timescale 1ns / 1ps
// Power-of-two slab allocator: classes of 16 << c bytes over a pool of pages.
// Each request takes one word on in and gives one word on out. Page state
// lives in a one-port page table memory and freed-object links in a link
// memory, both with registered reads. An allocate walks the class chain for
// a page with room and, when no chain page has room, scans the pool for an
// unused page to claim; a free that empties its page unlinks it from the
// class chain, walking the chain when the page is not the chain head. A
// result waits on out until it is taken. After reset the page table is
// cleared page by page while in is held off.
module bucket_slab_allocator_unit #(
  parameter int POOL_PAGES   = bsa_pkg::POOL_PAGES_DEF,
  parameter int PAGE_BYTES   = bsa_pkg::PAGE_BYTES_DEF,
  parameter int SIZE_CLASSES = bsa_pkg::SIZE_CLASSES_DEF
) (
  input  logic clk,
  input  logic rst,
  bsa_stream_if.sink   in,
  bsa_stream_if.source out
);
  import bsa_pkg::*;

  localparam int OBJ_MAX = PAGE_BYTES / MIN_OBJ_BYTES;
  localparam int OW  = $clog2(OBJ_MAX + 1);
  localparam int OIW = $clog2(OBJ_MAX);
  localparam int PW  = $clog2(POOL_PAGES + 1);
  localparam int PIW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int CW  = $clog2(SIZE_CLASSES + 1);
  localparam int CIW = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int PGB = $clog2(PAGE_BYTES);
  localparam int MSH = $clog2(MIN_OBJ_BYTES);
  localparam int LIW = PIW + OIW;
  localparam logic [OW-1:0] OBJ_NONE  = OW'(OBJ_MAX);
  localparam logic [PW-1:0] PAGE_NONE = PW'(POOL_PAGES);

  typedef struct packed {
    logic [CW-1:0] cls;
    logic [OW-1:0] cnt;
    logic [OW-1:0] head;
    logic [OW-1:0] fresh;
    logic [PW-1:0] link;
  } pent_t;

  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_AWALK = 5'd2,
                         S_AWCHK = 5'd3,  S_SCAN = 5'd4,  S_SCHK = 5'd5,
                         S_ATAKE = 5'd6,  S_ALINK = 5'd7, S_AFIN = 5'd8,
                         S_FRD = 5'd9,    S_FCHK = 5'd10, S_UWALK = 5'd11,
                         S_UCHK = 5'd12,  S_UFIX = 5'd13, S_OUT = 5'd14;

  pent_t ptab [POOL_PAGES];
  logic [OW-1:0] olink [POOL_PAGES*OBJ_MAX];
  logic [PW-1:0] chead [SIZE_CLASSES];

  logic [4:0] state;
  logic [PIW-1:0] paddr;
  logic pwe;
  pent_t pwd, prd;
  logic [LIW-1:0] laddr;
  logic lwe;
  logic [OW-1:0] lwd, lrd;

  req_t req;
  rsp_t rsp;
  logic [CIW-1:0] cls;
  logic [PW-1:0] cur, prev;
  logic [PW-1:0] cnt_steps;
  logic [OW-1:0] obj;
  pent_t ent;
  pent_t ent_alloc_next, ent_free_next;
  logic [PIW-1:0] tgt;

  always_ff @(posedge clk) begin
    if (pwe) ptab[paddr] <= pwd;
    prd <= ptab[paddr];
    if (lwe) olink[laddr] <= lwd;
    lrd <= olink[laddr];
  end

  function automatic logic [OW-1:0] objs_in(input logic [CIW-1:0] c);
    return OW'(OBJ_MAX >> c);
  endfunction

  // class select: smallest class that fits and stays within a page
  logic [CIW-1:0] sel_c;
  logic sel_ok;
  always_comb begin
    sel_c = '0;
    sel_ok = 1'b0;
    for (int c = SIZE_CLASSES - 1; c >= 0; c--) begin
      if ((MIN_OBJ_BYTES << c) <= PAGE_BYTES &&
          (MIN_OBJ_BYTES << c) >= int'(in.data.request_length)) begin
        sel_c = CIW'(c);
        sel_ok = 1'b1;
      end
    end
  end

  logic room;
  assign room = (prd.head != OBJ_NONE) || (prd.fresh < objs_in(cls));

  logic [PGB-1:0] off;
  logic [OW-1:0] fobj;
  logic [CIW-1:0] pcls;
  assign off = req.object_address[PGB-1:0];
  assign pcls = CIW'(prd.cls - CW'(1));
  assign fobj = OW'(off >> (32'(pcls) + MSH));

  logic [PGB:0] cbytes;
  assign cbytes = (PGB+1)'(MIN_OBJ_BYTES) << pcls;

  logic [17:0] pg_base;
  assign pg_base = 18'(32'(tgt) * PAGE_BYTES);

  always_comb begin
    ent_alloc_next = ent;
    if (ent.head != OBJ_NONE) ent_alloc_next.head = lrd;
    else ent_alloc_next.fresh = ent.fresh + OW'(1);
    ent_alloc_next.cnt = ent.cnt + OW'(1);
  end

  always_comb begin
    ent_free_next = prd;
    ent_free_next.head = fobj;
    ent_free_next.cnt = prd.cnt - OW'(1);
    if (prd.cnt == OW'(1))
      ent_free_next = '{cls: '0, cnt: '0, head: OBJ_NONE, fresh: '0, link: PAGE_NONE};
  end

  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_OUT);
  assign out.data = rsp;

  always_comb begin
    paddr = tgt;
    pwe = 1'b0;
    pwd = ent;
    laddr = {tgt, obj[OIW-1:0]};
    lwe = 1'b0;
    lwd = ent.head;
    case (state)
      S_CLEAR: begin
        pwe = 1'b1;
        pwd = '{cls: '0, cnt: '0, head: OBJ_NONE, fresh: '0, link: PAGE_NONE};
      end
      S_AWALK, S_UWALK, S_UCHK: paddr = cur[PIW-1:0];
      S_SCAN: paddr = cur[PIW-1:0];
      S_ATAKE: laddr = {tgt, ent.head[OIW-1:0]};
      S_AFIN: pwe = 1'b1;
      S_UFIX: begin
        paddr = cur[PIW-1:0];
        pwe = 1'b1;
        pwd = prd;
        pwd.link = prev;
      end
      S_FCHK: begin
        lwe = (prd.cls != '0) && !(req.size_hint != '0 &&
              32'(cbytes) < 32'(req.size_hint)) && fobj < prd.fresh &&
              fobj < OBJ_NONE;
        laddr = {tgt, fobj[OIW-1:0]};
        lwd = prd.head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      tgt <= '0;
      for (int c = 0; c < SIZE_CLASSES; c++) chead[c] <= PAGE_NONE;
    end else begin
      case (state)
        S_CLEAR: begin
          tgt <= tgt + PIW'(1);
          if (32'(tgt) == POOL_PAGES - 1) state <= S_IDLE;
        end
        S_IDLE: if (in.valid) begin
          req <= in.data;
          cnt_steps <= '0;
          if (in.data.command == CMD_ALLOC) begin
            cls <= sel_c;
            if (!sel_ok) begin
              rsp <= '{result_address: '0, status: ST_TOO_LARGE, page_released: 1'b0};
              state <= S_OUT;
            end else begin
              rsp <= '{result_address: '0, status: ST_OK, page_released: 1'b0};
              cur <= chead[sel_c];
              state <= S_AWALK;
            end
          end else begin
            if (32'(in.data.object_address >> PGB) >= POOL_PAGES) begin
              rsp <= '{result_address: '0, status: ST_BAD_ADDRESS, page_released: 1'b0};
              state <= S_OUT;
            end else begin
              rsp <= '{result_address: '0, status: ST_OK, page_released: 1'b0};
              tgt <= PIW'(in.data.object_address >> PGB);
              state <= S_FRD;
            end
          end
        end
        S_AWALK: begin
          if (cur >= PAGE_NONE || 32'(cnt_steps) >= POOL_PAGES) begin
            cur <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_AWCHK;
          end
        end
        S_AWCHK: begin
          if (room) begin
            tgt <= cur[PIW-1:0];
            ent <= prd;
            state <= S_ATAKE;
          end else begin
            cur <= prd.link;
            cnt_steps <= cnt_steps + PW'(1);
            state <= S_AWALK;
          end
        end
        S_SCAN: begin
          if (cur >= PAGE_NONE) begin
            rsp.status <= ST_NO_MEMORY;
            state <= S_OUT;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (prd.cls == '0) begin
            tgt <= cur[PIW-1:0];
            ent <= '{cls: CW'(cls) + CW'(1), cnt: '0, head: OBJ_NONE, fresh: '0,
                     link: chead[cls]};
            chead[cls] <= cur;
            state <= S_ATAKE;
          end else begin
            cur <= cur + PW'(1);
            state <= S_SCAN;
          end
        end
        S_ATAKE: begin
          if (ent.head != OBJ_NONE) obj <= ent.head;
          else obj <= ent.fresh;
          state <= S_ALINK;
        end
        S_ALINK: begin
          ent <= ent_alloc_next;
          rsp.result_address <= pg_base + 18'(32'(obj) << (32'(cls) + MSH));
          state <= S_AFIN;
        end
        S_AFIN: state <= S_OUT;
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          cls <= pcls;
          if (!lwe) begin
            rsp.status <= ST_BAD_ADDRESS;
            state <= S_OUT;
          end else begin
            ent <= ent_free_next;
            if (prd.cnt == OW'(1)) begin
              rsp.page_released <= 1'b1;
              if (chead[pcls] == PW'(tgt)) begin
                chead[pcls] <= prd.link;
                state <= S_AFIN;
              end else begin
                prev <= prd.link;
                cur <= chead[pcls];
                state <= S_UWALK;
              end
            end else begin
              state <= S_AFIN;
            end
          end
        end
        S_UWALK: begin
          if (cur >= PAGE_NONE || 32'(cnt_steps) >= POOL_PAGES) state <= S_AFIN;
          else state <= S_UCHK;
        end
        S_UCHK: begin
          if (prd.link == PW'(tgt)) begin
            state <= S_UFIX;
          end else begin
            cur <= prd.link;
            cnt_steps <= cnt_steps + PW'(1);
            state <= S_UWALK;
          end
        end
        S_UFIX: state <= S_AFIN;
        S_OUT: if (out.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in.ready && out.valid))
    else $error("accept during output");
  a_rel_ok: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.data.page_released |-> out.data.status == ST_OK)
    else $error("release with fault");
endmodule
